// ----- rtl/pps_pkg.sv -----
package pps_pkg;

    localparam int DEPTH_W = 6;
    localparam int WIDTH_W = 13;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int VAL_W   = 24;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DEPTH_W-1:0] RESET_DEPTH = 6'd8;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd640;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DEPTH = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    typedef enum logic {
        REG_DEPTH = 1'b0,
        REG_WIDTH = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_W,
        S_MUL_C,
        S_MUL_R,
        S_CHECK,
        S_RD,
        S_RDW,
        S_WR,
        S_DONE
    } t_state;

    function automatic logic f_depth_ok(input logic [DEPTH_W-1:0] d);
        return (d == 6'd1) || (d == 6'd2) || (d == 6'd4) || (d == 6'd8) ||
               (d == 6'd16) || (d == 6'd24);
    endfunction

    // bytes touched by one pixel
    function automatic logic [1:0] f_span(input logic [DEPTH_W-1:0] d);
        logic [1:0] s;
        case (d)
            6'd16:   s = 2'd2;
            6'd24:   s = 2'd3;
            default: s = 2'd1;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/pps_ram.sv -----
module pps_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pps_mac.sv -----
module pps_mac #(
    parameter int AW = 16,
    parameter int BW = 12,
    parameter int RW = 29
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    input  logic [RW-1:0] i_c,
    output logic [RW-1:0] o_acc
);

    logic [AW+BW-1:0] w_prod;
    logic [RW-1:0]    r_acc;
    logic [RW-1:0]    n_acc;

    assign w_prod = i_a * i_b;
    assign n_acc  = RW'(w_prod) + i_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/packed_pixel_store_core.sv -----
// Packed pixel store: a byte-wide memory of STORE_BYTES bytes holding one image at
// 1, 2, 4, 8, 16 or 24 bits per pixel, rows padded to 4-byte multiples. Each
// transaction reads or writes one pixel and returns one result with a status. The
// byte address is formed by three passes through one shared multiply-add unit
// (stride, column offset, row base), then the memory is accessed one byte at a
// time, each byte read passing through S_RD and then S_RDW. An unsupported depth
// goes straight to the result, an address beyond the store ends after the range
// check, 1/2/4/8-bit pixels take one byte read (plus a merged write-back for a
// write) and 16/24-bit pixels read or write each of their bytes in turn; a result
// waits in S_DONE while the output is stalled. After reset the memory is zeroed
// one byte per cycle, so no transaction is taken until the whole store is cleared;
// register writes are taken throughout.
module packed_pixel_store_core #(
    parameter int STORE_BYTES = 262144,
    parameter int MAX_WIDTH   = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pps_pkg::PADDR_W-1:0]          paddr,
    input  logic [pps_pkg::PDATA_W-1:0]          pwdata,
    output logic [pps_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_func,
    input  logic [pps_pkg::ROW_W-1:0]            i_row,
    input  logic [pps_pkg::COL_W-1:0]            i_column,
    input  logic [pps_pkg::VAL_W-1:0]            i_pixel_value,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [pps_pkg::VAL_W-1:0]            o_read_value,
    output logic [pps_pkg::STAT_W-1:0]           o_status
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int SW     = WW + 2;
    localparam int AW     = (SW > pps_pkg::COL_W) ? SW : pps_pkg::COL_W;
    localparam int BW     = pps_pkg::ROW_W;
    localparam int RW     = AW + BW + 1;

    pps_pkg::t_state              r_state;
    pps_pkg::t_state              n_state;
    logic [ADDR_W-1:0]            r_clr;
    logic [pps_pkg::DEPTH_W-1:0]  r_depth;
    logic [pps_pkg::WIDTH_W-1:0]  r_width;
    pps_pkg::t_func               r_func;
    logic [pps_pkg::ROW_W-1:0]    r_row;
    logic [pps_pkg::COL_W-1:0]    r_column;
    logic [pps_pkg::VAL_W-1:0]    r_value;
    logic [SW-1:0]                r_stride;
    logic [2:0]                   r_off;
    logic [ADDR_W-1:0]            r_addr;
    logic [1:0]                   r_k;
    logic [pps_pkg::VAL_W-1:0]    r_result;
    logic [7:0]                   r_wbyte;
    pps_pkg::t_status             r_status;
    logic                         r_out_valid;
    logic [pps_pkg::VAL_W-1:0]    r_out_value;
    pps_pkg::t_status             r_out_status;

    logic                         w_cfg_wr;
    logic [WW-1:0]                w_clamp;
    logic [RW-1:0]                w_acc;
    logic [RW:0]                  w_end;
    logic                         w_over;
    logic                         w_narrow;
    logic [1:0]                   w_span;
    logic                         w_last;
    logic                         w_out_free;
    logic [ADDR_W-1:0]            w_byte_addr;
    logic [3:0]                   w_shift;
    logic [7:0]                   w_field;
    logic [7:0]                   w_mask;
    logic [7:0]                   w_rdata;
    logic [7:0]                   w_merged;

    logic                         mac_en;
    logic [AW-1:0]                mac_a;
    logic [BW-1:0]                mac_b;
    logic [RW-1:0]                mac_c;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [7:0]                   mem_wdata;
    logic [ADDR_W-1:0]            mem_raddr;

    pps_mac #(
        .AW (AW),
        .BW (BW),
        .RW (RW)
    ) u_mac (
        .i_clk (i_clk),
        .i_en  (mac_en),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_acc (w_acc)
    );

    pps_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (w_rdata)
    );

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (pps_pkg::t_reg'(paddr[2]))
            pps_pkg::REG_DEPTH: prdata = pps_pkg::PDATA_W'(r_depth);
            pps_pkg::REG_WIDTH: prdata = pps_pkg::PDATA_W'(r_width);
            default:            prdata = '0;
        endcase
    end

    // datapath helpers
    always_comb begin
        if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(r_width);
        end
    end

    assign w_span      = pps_pkg::f_span(r_depth);
    assign w_narrow    = (r_depth <= 6'd8);
    assign w_last      = (r_k == (w_span - 2'd1));
    assign w_end       = {1'b0, w_acc} + (RW+1)'(w_span);
    assign w_over      = w_end > (RW+1)'(STORE_BYTES);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_byte_addr = r_addr + ADDR_W'(r_k);
    assign w_shift     = 4'(4'd8 - 4'(r_depth) - {1'b0, r_off});
    assign w_field     = 8'((9'd1 << r_depth) - 9'd1);
    assign w_mask      = w_field << w_shift;
    assign w_merged    = (w_rdata & ~w_mask) | ((r_value[7:0] << w_shift) & w_mask);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pps_pkg::S_CLEAR: begin
                if (r_clr == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = pps_pkg::S_IDLE;
                end
            end
            pps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pps_pkg::f_depth_ok(r_depth) ? pps_pkg::S_MUL_W
                                                           : pps_pkg::S_DONE;
                end
            end
            pps_pkg::S_MUL_W: n_state = pps_pkg::S_MUL_C;
            pps_pkg::S_MUL_C: n_state = pps_pkg::S_MUL_R;
            pps_pkg::S_MUL_R: n_state = pps_pkg::S_CHECK;
            pps_pkg::S_CHECK: begin
                if (w_over) begin
                    n_state = pps_pkg::S_DONE;
                end else if (!w_narrow && r_func == pps_pkg::FUNC_WRITE) begin
                    n_state = pps_pkg::S_WR;
                end else begin
                    n_state = pps_pkg::S_RD;
                end
            end
            pps_pkg::S_RD: n_state = pps_pkg::S_RDW;
            pps_pkg::S_RDW: begin
                if (w_narrow) begin
                    n_state = (r_func == pps_pkg::FUNC_WRITE) ? pps_pkg::S_WR
                                                              : pps_pkg::S_DONE;
                end else begin
                    n_state = w_last ? pps_pkg::S_DONE : pps_pkg::S_RD;
                end
            end
            pps_pkg::S_WR: begin
                if (w_narrow || w_last) begin
                    n_state = pps_pkg::S_DONE;
                end
            end
            pps_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = pps_pkg::S_IDLE;
                end
            end
            default: n_state = pps_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        mac_en    = 1'b0;
        mac_a     = '0;
        mac_b     = '0;
        mac_c     = '0;
        mem_we    = 1'b0;
        mem_waddr = w_byte_addr;
        mem_wdata = 8'h00;
        mem_raddr = w_byte_addr;
        case (r_state)
            pps_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            pps_pkg::S_MUL_W: begin
                mac_en = 1'b1;
                mac_a  = AW'(w_clamp);
                mac_b  = BW'(r_depth);
                mac_c  = RW'(31);
            end
            pps_pkg::S_MUL_C: begin
                mac_en = 1'b1;
                mac_a  = AW'(r_column);
                mac_b  = BW'(r_depth);
            end
            pps_pkg::S_MUL_R: begin
                mac_en = 1'b1;
                mac_a  = AW'(r_stride);
                mac_b  = r_row;
                mac_c  = RW'(w_acc[RW-1:3]);
            end
            pps_pkg::S_WR: begin
                mem_we = 1'b1;
                if (w_narrow) begin
                    mem_wdata = r_wbyte;
                end else begin
                    case (r_k)
                        2'd0:    mem_wdata = r_value[7:0];
                        2'd1:    mem_wdata = r_value[15:8];
                        default: mem_wdata = r_value[23:16];
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pps_pkg::S_CLEAR;
            r_clr       <= '0;
            r_depth     <= pps_pkg::RESET_DEPTH;
            r_width     <= pps_pkg::RESET_WIDTH;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                case (pps_pkg::t_reg'(paddr[2]))
                    pps_pkg::REG_DEPTH: r_depth <= pwdata[pps_pkg::DEPTH_W-1:0];
                    pps_pkg::REG_WIDTH: r_width <= pwdata[pps_pkg::WIDTH_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == pps_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                pps_pkg::S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                end
                pps_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_func   <= pps_pkg::t_func'(i_func);
                        r_row    <= i_row;
                        r_column <= i_column;
                        r_value  <= i_pixel_value;
                        r_result <= '0;
                        r_k      <= '0;
                        r_status <= pps_pkg::f_depth_ok(r_depth) ? pps_pkg::ST_OK
                                                                 : pps_pkg::ST_DEPTH;
                    end
                end
                pps_pkg::S_MUL_C: begin
                    r_stride <= SW'({w_acc[RW-1:5], 2'b00});
                end
                pps_pkg::S_MUL_R: begin
                    r_off <= w_acc[2:0];
                end
                pps_pkg::S_CHECK: begin
                    r_addr <= w_acc[ADDR_W-1:0];
                    if (w_over) begin
                        r_status <= pps_pkg::ST_RANGE;
                    end
                end
                pps_pkg::S_RDW: begin
                    if (w_narrow) begin
                        if (r_func == pps_pkg::FUNC_WRITE) begin
                            r_wbyte <= w_merged;
                        end else begin
                            r_result <= pps_pkg::VAL_W'((w_rdata >> w_shift) & w_field);
                        end
                    end else begin
                        case (r_k)
                            2'd0:    r_result[7:0]   <= w_rdata;
                            2'd1:    r_result[15:8]  <= w_rdata;
                            default: r_result[23:16] <= w_rdata;
                        endcase
                        if (!w_last) begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                pps_pkg::S_WR: begin
                    if (!w_narrow && !w_last) begin
                        r_k <= r_k + 2'd1;
                    end
                end
                pps_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_out_value  <= r_result;
                        r_out_status <= r_status;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != pps_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pps_pkg::S_DONE && w_out_free) |=> r_out_valid)
        else $error("finished transaction did not reach the output register");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pps_pkg::ST_OK) |-> (o_read_value == '0))
        else $error("error result carries a nonzero read value");

    a_byte_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pps_pkg::S_RDW || r_state == pps_pkg::S_WR) |->
            (r_k < pps_pkg::f_span(r_depth)))
        else $error("byte index past pixel span");

endmodule
